>>> rtl/core/vm_thread_fetch_stack_unit_defines.svh
// Assertion macros shared by the thread fetch/stack unit RTL.
// No dependencies; expects i_clk and i_rst_n in the including scope.
`ifndef VM_THREAD_FETCH_STACK_UNIT_DEFINES_SVH
`define VM_THREAD_FETCH_STACK_UNIT_DEFINES_SVH

// Same-cycle implication or plain property, checked out of reset.
`define VTFS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Next-cycle implication: ante |=> cons.
`define VTFS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/vtfs_pkg.sv
// Package for the thread fetch/stack unit: sizes, codes, transaction types,
// memory request types and the address resolve function. No dependencies.
package vtfs_pkg;

    // Memory sizes (powers of two)
    localparam int CODE_BYTES  = 65536;
    localparam int STACK_DEPTH = 256;
    localparam int LOCAL_BYTES = 4096;
    localparam int AUX_SLOTS   = 32;

    localparam int CODE_AW    = $clog2(CODE_BYTES);
    localparam int CODE_ROWS  = CODE_BYTES / 4;
    localparam int CODE_RW    = CODE_AW - 2;
    localparam int STACK_AW   = $clog2(STACK_DEPTH);
    localparam int LOCAL_AW   = $clog2(LOCAL_BYTES);
    localparam int LOCAL_ROWS = LOCAL_BYTES / 4;
    localparam int LOCAL_RW   = LOCAL_AW - 2;

    localparam int SP_W             = 9;
    localparam int AUX_PRESENT_BITS = 32;

    // Operations
    localparam logic [3:0] OP_LOAD_CODE   = 4'd0;
    localparam logic [3:0] OP_FETCH       = 4'd1;
    localparam logic [3:0] OP_READ8       = 4'd2;
    localparam logic [3:0] OP_READ16      = 4'd3;
    localparam logic [3:0] OP_READ32      = 4'd4;
    localparam logic [3:0] OP_PUSH        = 4'd5;
    localparam logic [3:0] OP_POP         = 4'd6;
    localparam logic [3:0] OP_POP_RESOLVE = 4'd7;
    localparam logic [3:0] OP_RESOLVE     = 4'd8;
    localparam logic [3:0] OP_SET_IP      = 4'd9;
    localparam logic [3:0] OP_SET_BP      = 4'd10;
    localparam logic [3:0] OP_PUSH_RET    = 4'd11;
    localparam logic [3:0] OP_POP_RET     = 4'd12;

    // Status codes
    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_NULL       = 3'd1;
    localparam logic [2:0] ST_STRUCT     = 3'd2;
    localparam logic [2:0] ST_INVALID    = 3'd3;
    localparam logic [2:0] ST_UNINIT_AUX = 3'd4;
    localparam logic [2:0] ST_WRAP       = 3'd5;

    // Regions
    localparam logic [2:0] RG_NONE   = 3'd0;
    localparam logic [2:0] RG_GLOBAL = 3'd1;
    localparam logic [2:0] RG_LOCAL  = 3'd2;
    localparam logic [2:0] RG_CODE   = 3'd3;
    localparam logic [2:0] RG_AUX    = 3'd4;

    // Address tags
    localparam logic [7:0] TAG_GLOBAL   = 8'h00;
    localparam logic [7:0] TAG_LOCAL    = 8'h10;
    localparam logic [7:0] TAG_CODE     = 8'h11;
    localparam logic [7:0] TAG_STRUCT   = 8'h12;
    localparam logic [7:0] TAG_AUX_BASE = 8'h40;

    // Config register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_STACK_LIMIT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_AUX_PRESENT = 1'd1;

    typedef struct packed {
        logic [3:0]  operation;
        logic [31:0] value;
        logic [15:0] code_address;
    } t_item;

    typedef struct packed {
        logic [31:0]     data;
        logic [2:0]      region;
        logic [6:0]      aux_slot;
        logic [23:0]     offset;
        logic [2:0]      status;
        logic            fault;
        logic [31:0]     instr_pointer;
        logic [31:0]     next_pointer;
        logic [31:0]     base_pointer;
        logic [SP_W-1:0] stack_pointer;
    } t_result;

    typedef struct packed {
        logic               rd;
        logic               wr;
        logic [CODE_AW-1:0] addr;
        logic [7:0]         wdata;
    } t_code_req;

    typedef struct packed {
        logic                rd;
        logic                wr;
        logic [STACK_AW-1:0] addr;
        logic [31:0]         wdata;
    } t_stack_req;

    typedef struct packed {
        logic                rd;
        logic                wr;
        logic [LOCAL_AW-1:0] addr;
        logic [31:0]         wdata;
    } t_frame_req;

    typedef struct packed {
        logic [2:0]  region;
        logic [6:0]  slot;
        logic [23:0] offset;
        logic [2:0]  status;
        logic        fault;
    } t_resolve;

    function automatic t_resolve resolve_addr(input logic [31:0] addr,
                                              input logic [31:0] aux);
        t_resolve   r;
        logic [7:0] tag;
        logic [6:0] slot;
        r        = '0;
        r.offset = addr[23:0];
        tag      = addr[31:24];
        slot     = tag[7:1] - 7'd32;
        if (addr == 32'd0) begin
            r.status = ST_NULL;
        end else if (tag == TAG_GLOBAL) begin
            r.region = RG_GLOBAL;
        end else if (tag == TAG_LOCAL) begin
            r.region = RG_LOCAL;
        end else if (tag == TAG_CODE) begin
            r.region = RG_CODE;
        end else if (tag == TAG_STRUCT) begin
            r.status = ST_STRUCT;
        end else if (tag < TAG_AUX_BASE) begin
            r.status = ST_INVALID;
        end else begin
            r.slot = slot;
            if (slot < 7'(AUX_SLOTS) && slot < 7'(AUX_PRESENT_BITS) && aux[slot[4:0]]) begin
                r.region = RG_AUX;
            end else begin
                r.status = ST_UNINIT_AUX;
                r.fault  = 1'b1;
            end
        end
        return r;
    endfunction

endpackage

>>> rtl/core/vtfs_code_mem.sv
// Code memory: four byte banks, one byte write, unaligned 32-bit LE read.
// Depends on vtfs_pkg.
module vtfs_code_mem (
    input  logic                i_clk,
    input  vtfs_pkg::t_code_req i_req,
    output logic [31:0]         o_rdata
);

    logic [7:0] r_q [4];
    logic [1:0] r_lane;

    for (genvar g = 0; g < 4; g++) begin : g_bank
        logic [7:0]                   r_mem [vtfs_pkg::CODE_ROWS];
        logic [1:0]                   w_ofs;
        logic [vtfs_pkg::CODE_AW-1:0] w_byte;
        logic [vtfs_pkg::CODE_RW-1:0] w_row;
        logic                         w_we;

        assign w_ofs  = 2'(g) - i_req.addr[1:0];
        assign w_byte = i_req.addr + vtfs_pkg::CODE_AW'(w_ofs);
        assign w_row  = w_byte[vtfs_pkg::CODE_AW-1:2];
        assign w_we   = i_req.wr && (i_req.addr[1:0] == 2'(g));

        always_ff @(posedge i_clk) begin
            if (w_we) begin
                r_mem[w_row] <= i_req.wdata;
            end
            if (i_req.rd) begin
                r_q[g] <= r_mem[w_row];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.rd) begin
            r_lane <= i_req.addr[1:0];
        end
    end

    // realign: byte i came from bank lane+i
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            o_rdata[8*i +: 8] = r_q[2'(r_lane + 2'(i))];
        end
    end

endmodule

>>> rtl/core/vtfs_stack_mem.sv
// Data stack memory with per-entry valid bits; unwritten entries read zero.
// Depends on vtfs_pkg.
module vtfs_stack_mem (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  vtfs_pkg::t_stack_req i_req,
    output logic [31:0]          o_rdata
);

    logic [31:0]                     r_mem [vtfs_pkg::STACK_DEPTH];
    logic [vtfs_pkg::STACK_DEPTH-1:0] r_valid;
    logic [31:0]                     r_q;
    logic                            r_q_valid;

    always_ff @(posedge i_clk) begin
        if (i_req.wr) begin
            r_mem[i_req.addr] <= i_req.wdata;
        end
        if (i_req.rd) begin
            r_q <= r_mem[i_req.addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= '0;
            r_q_valid <= 1'b0;
        end else begin
            if (i_req.wr) begin
                r_valid[i_req.addr] <= 1'b1;
            end
            if (i_req.rd) begin
                r_q_valid <= r_valid[i_req.addr];
            end
        end
    end

    assign o_rdata = r_q_valid ? r_q : 32'd0;

endmodule

>>> rtl/core/vtfs_frame_mem.sv
// Frame (local) memory: four byte banks, unaligned 32-bit LE read and write,
// zero-fill sweep after reset. Depends on vtfs_pkg.
module vtfs_frame_mem (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  vtfs_pkg::t_frame_req i_req,
    output logic [31:0]          o_rdata,
    output logic                 o_clearing
);

    logic [7:0]                    r_q [4];
    logic [1:0]                    r_lane;
    logic                          r_clearing;
    logic [vtfs_pkg::LOCAL_RW-1:0] r_clr_row;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_row  <= '0;
        end else if (r_clearing) begin
            r_clr_row <= r_clr_row + 1'b1;
            if (r_clr_row == vtfs_pkg::LOCAL_RW'(vtfs_pkg::LOCAL_ROWS - 1)) begin
                r_clearing <= 1'b0;
            end
        end
    end

    for (genvar g = 0; g < 4; g++) begin : g_bank
        logic [7:0]                    r_mem [vtfs_pkg::LOCAL_ROWS];
        logic [1:0]                    w_ofs;
        logic [vtfs_pkg::LOCAL_AW-1:0] w_byte;
        logic [vtfs_pkg::LOCAL_RW-1:0] w_row;

        assign w_ofs  = 2'(g) - i_req.addr[1:0];
        assign w_byte = i_req.addr + vtfs_pkg::LOCAL_AW'(w_ofs);
        assign w_row  = w_byte[vtfs_pkg::LOCAL_AW-1:2];

        always_ff @(posedge i_clk) begin
            if (r_clearing) begin
                r_mem[r_clr_row] <= 8'd0;
            end else if (i_req.wr) begin
                r_mem[w_row] <= i_req.wdata[8*w_ofs +: 8];
            end
            if (i_req.rd) begin
                r_q[g] <= r_mem[w_row];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.rd) begin
            r_lane <= i_req.addr[1:0];
        end
    end

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            o_rdata[8*i +: 8] = r_q[2'(r_lane + 2'(i))];
        end
    end

    assign o_clearing = r_clearing;

endmodule

>>> rtl/core/vm_thread_fetch_stack_unit.sv
// Top level of the thread fetch/stack unit: control, pointers, config.
// Depends on vtfs_pkg, vtfs_code_mem, vtfs_stack_mem, vtfs_frame_mem and
// vm_thread_fetch_stack_unit_defines.svh.
//
// One operation per transaction: start is taken at a rising edge where busy
// is low. The accept edge issues the memory reads (code at next_ip, stack at
// the pop slot, frame at base_pointer-4); the following cycle does the
// modify/write-back and registers the result, which shows on o_result with
// o_strobe high for exactly one cycle right after. busy is high during that
// execute cycle, so a new transaction cannot be taken until the current one
// has executed, as the memory reads are registered. Results cannot be held off
// by the receiver. After reset busy stays high while the frame memory is
// zero-filled one row per cycle, and until control then moves out of the clear
// state. Configuration writes are taken whenever no transaction is in flight,
// including that sweep, and take effect on the next transaction. Reads of
// code bytes never loaded return unspecified data.
`include "vm_thread_fetch_stack_unit_defines.svh"

module vm_thread_fetch_stack_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  vtfs_pkg::t_item                     i_item,
    input  logic                                i_cfg_we,
    input  logic [vtfs_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [31:0]                         i_cfg_wdata,
    output logic                                o_strobe,
    output vtfs_pkg::t_result                   o_result
);

    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_EXEC  = 2'd2;

    localparam int SP_W = vtfs_pkg::SP_W;

    logic [1:0]        r_state;
    vtfs_pkg::t_item   r_item;
    logic [SP_W-1:0]   r_limit;
    logic [31:0]       r_aux_present;
    logic [SP_W-1:0]   r_sp;
    logic [31:0]       r_cur_ip;
    logic [31:0]       r_next_ip;
    logic [31:0]       r_fp;
    logic              r_fault;
    logic              r_strobe;
    vtfs_pkg::t_result r_result;

    logic [SP_W-1:0]   n_sp;
    logic [31:0]       n_cur_ip;
    logic [31:0]       n_next_ip;
    logic [31:0]       n_fp;
    logic              n_fault;
    vtfs_pkg::t_result n_result;

    logic              w_accept;
    logic              w_exec;
    logic              w_clearing;
    logic [SP_W-1:0]   w_lim;
    logic              w_push_wrap;
    logic [SP_W-1:0]   w_push_idx;
    logic              w_pop_wrap;
    logic [SP_W-1:0]   w_pop_idx;
    logic [31:0]       w_fp_dec;
    logic [31:0]       w_code_rdata;
    logic [31:0]       w_stack_rdata;
    logic [31:0]       w_frame_rdata;
    logic [31:0]       w_rsv_addr;
    vtfs_pkg::t_resolve w_rsv;

    vtfs_pkg::t_code_req  w_code_req;
    vtfs_pkg::t_stack_req w_stack_req;
    vtfs_pkg::t_frame_req w_frame_req;

    assign busy     = (r_state != S_IDLE);
    assign w_accept = start && !busy;
    assign w_exec   = (r_state == S_EXEC);

    // effective stack limit: 0 acts as 1, above the depth clamps
    always_comb begin
        if (r_limit == '0) begin
            w_lim = SP_W'(1);
        end else if (r_limit > SP_W'(vtfs_pkg::STACK_DEPTH)) begin
            w_lim = SP_W'(vtfs_pkg::STACK_DEPTH);
        end else begin
            w_lim = r_limit;
        end
    end

    // push wraps to 0 at the limit; pop wraps to the limit at 0
    assign w_push_wrap = (r_sp >= w_lim);
    assign w_push_idx  = w_push_wrap ? '0 : r_sp;
    assign w_pop_wrap  = (r_sp == '0) || (r_sp > w_lim);
    assign w_pop_idx   = (w_pop_wrap ? w_lim : r_sp) - 1'b1;
    assign w_fp_dec    = r_fp - 32'd4;

    // ---- memory requests: reads at accept, writes in the execute cycle ----
    always_comb begin
        w_code_req.rd    = w_accept && ((i_item.operation == vtfs_pkg::OP_FETCH)
                                     || (i_item.operation == vtfs_pkg::OP_READ8)
                                     || (i_item.operation == vtfs_pkg::OP_READ16)
                                     || (i_item.operation == vtfs_pkg::OP_READ32));
        w_code_req.wr    = w_exec && (r_item.operation == vtfs_pkg::OP_LOAD_CODE);
        w_code_req.addr  = w_exec ? vtfs_pkg::CODE_AW'(r_item.code_address)
                                  : r_next_ip[vtfs_pkg::CODE_AW-1:0];
        w_code_req.wdata = r_item.value[7:0];

        w_stack_req.rd    = w_accept && ((i_item.operation == vtfs_pkg::OP_POP)
                                      || (i_item.operation == vtfs_pkg::OP_POP_RESOLVE));
        w_stack_req.wr    = w_exec && (r_item.operation == vtfs_pkg::OP_PUSH);
        w_stack_req.addr  = w_exec ? w_push_idx[vtfs_pkg::STACK_AW-1:0]
                                   : w_pop_idx[vtfs_pkg::STACK_AW-1:0];
        w_stack_req.wdata = r_item.value;

        w_frame_req.rd    = w_accept && (i_item.operation == vtfs_pkg::OP_POP_RET);
        w_frame_req.wr    = w_exec && (r_item.operation == vtfs_pkg::OP_PUSH_RET);
        w_frame_req.addr  = w_exec ? r_fp[vtfs_pkg::LOCAL_AW-1:0]
                                   : w_fp_dec[vtfs_pkg::LOCAL_AW-1:0];
        w_frame_req.wdata = r_item.value;
    end

    vtfs_code_mem u_code (
        .i_clk   (i_clk),
        .i_req   (w_code_req),
        .o_rdata (w_code_rdata)
    );

    vtfs_stack_mem u_stack (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_stack_req),
        .o_rdata (w_stack_rdata)
    );

    vtfs_frame_mem u_frame (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (w_frame_req),
        .o_rdata    (w_frame_rdata),
        .o_clearing (w_clearing)
    );

    // one resolve unit, fed by the popped word or the operand
    assign w_rsv_addr = (r_item.operation == vtfs_pkg::OP_POP_RESOLVE) ? w_stack_rdata
                                                                       : r_item.value;
    assign w_rsv = vtfs_pkg::resolve_addr(w_rsv_addr, r_aux_present);

    // ---- execute: modify state, build the result ----
    always_comb begin
        n_sp      = r_sp;
        n_cur_ip  = r_cur_ip;
        n_next_ip = r_next_ip;
        n_fp      = r_fp;
        n_fault   = r_fault;
        n_result  = '0;

        case (r_item.operation)
            vtfs_pkg::OP_FETCH: begin
                n_cur_ip      = r_next_ip;
                n_result.data = {24'd0, w_code_rdata[7:0]};
                n_next_ip     = r_next_ip + 32'd1;
            end
            vtfs_pkg::OP_READ8: begin
                n_result.data = {24'd0, w_code_rdata[7:0]};
                n_next_ip     = r_next_ip + 32'd1;
            end
            vtfs_pkg::OP_READ16: begin
                n_result.data = {16'd0, w_code_rdata[15:0]};
                n_next_ip     = r_next_ip + 32'd2;
            end
            vtfs_pkg::OP_READ32: begin
                n_result.data = w_code_rdata;
                n_next_ip     = r_next_ip + 32'd4;
            end
            vtfs_pkg::OP_PUSH: begin
                if (w_push_wrap) begin
                    n_result.status = vtfs_pkg::ST_WRAP;
                end
                n_sp = w_push_idx + 1'b1;
            end
            vtfs_pkg::OP_POP: begin
                if (w_pop_wrap) begin
                    n_result.status = vtfs_pkg::ST_WRAP;
                end
                n_sp          = w_pop_idx;
                n_result.data = w_stack_rdata;
            end
            vtfs_pkg::OP_POP_RESOLVE: begin
                n_sp              = w_pop_idx;
                n_result.data     = w_stack_rdata;
                n_result.region   = w_rsv.region;
                n_result.aux_slot = w_rsv.slot;
                n_result.offset   = w_rsv.offset;
                // a resolve error outranks the wrap flag
                if (w_rsv.status != vtfs_pkg::ST_OK) begin
                    n_result.status = w_rsv.status;
                end else if (w_pop_wrap) begin
                    n_result.status = vtfs_pkg::ST_WRAP;
                end
                n_fault = r_fault | w_rsv.fault;
            end
            vtfs_pkg::OP_RESOLVE: begin
                n_result.region   = w_rsv.region;
                n_result.aux_slot = w_rsv.slot;
                n_result.offset   = w_rsv.offset;
                n_result.status   = w_rsv.status;
                n_fault           = r_fault | w_rsv.fault;
            end
            vtfs_pkg::OP_SET_IP: begin
                n_next_ip = r_item.value;
            end
            vtfs_pkg::OP_SET_BP: begin
                n_fp = r_item.value;
            end
            vtfs_pkg::OP_PUSH_RET: begin
                n_fp = r_fp + 32'd4;
            end
            vtfs_pkg::OP_POP_RET: begin
                n_fp          = w_fp_dec;
                n_result.data = w_frame_rdata;
            end
            default: begin
                // load code byte and unused codes: no state change here
            end
        endcase

        n_result.fault         = n_fault;
        n_result.instr_pointer = n_cur_ip;
        n_result.next_pointer  = n_next_ip;
        n_result.base_pointer  = n_fp;
        n_result.stack_pointer = n_sp;
    end

    // ---- control and architectural registers ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_sp      <= '0;
            r_cur_ip  <= '0;
            r_next_ip <= '0;
            r_fp      <= '0;
            r_fault   <= 1'b0;
            r_strobe  <= 1'b0;
        end else begin
            r_strobe <= 1'b0;
            case (r_state)
                S_CLEAR: begin
                    if (!w_clearing) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (w_accept) begin
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    r_state   <= S_IDLE;
                    r_sp      <= n_sp;
                    r_cur_ip  <= n_cur_ip;
                    r_next_ip <= n_next_ip;
                    r_fp      <= n_fp;
                    r_fault   <= n_fault;
                    r_strobe  <= 1'b1;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit       <= SP_W'(256);
            r_aux_present <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                vtfs_pkg::CFG_STACK_LIMIT: r_limit       <= i_cfg_wdata[SP_W-1:0];
                vtfs_pkg::CFG_AUX_PRESENT: r_aux_present <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item <= i_item;
        end
        if (w_exec) begin
            r_result <= n_result;
        end
    end

    assign o_strobe = r_strobe;
    assign o_result = r_result;

    // ---- assertions ----
    `VTFS_ASSERT_NEXT(a_accept_exec, w_accept, r_state == S_EXEC, "accept without execute")
    `VTFS_ASSERT_NEXT(a_exec_strobe, w_exec, o_strobe && !w_exec, "execute gave no strobe")
    `VTFS_ASSERT_NEXT(a_fault_sticky, r_fault, r_fault, "fault flag cleared outside reset")
    `VTFS_ASSERT(a_uninit_fault, (o_strobe && o_result.status == vtfs_pkg::ST_UNINIT_AUX) |-> o_result.fault, "aux status without fault")
    `VTFS_ASSERT(a_sp_range, o_strobe |-> (o_result.stack_pointer <= SP_W'(vtfs_pkg::STACK_DEPTH)), "stack pointer beyond depth")

endmodule
